// ===== hw/rtl/rgbfs_pkg.sv =====
// Shared types and constants for the RGB565 to RGB666 fill stream.
// No dependencies.
`default_nettype none

package rgbfs_pkg;

   // Job kinds, as classified by the front end
   localparam logic [1:0] JOB_PIXEL = 2'd0;   // one converted pixel
   localparam logic [1:0] JOB_FILL  = 2'd1;   // plain colour, one repeated group
   localparam logic [1:0] JOB_PURE  = 2'd2;   // pure colour, 3-bit fast path

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] code;         // pair code of a pure colour
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic       block_end;
   } job_type;

   typedef struct packed {
      logic [7:0] format_command;
      logic [7:0] continue_command;
      logic [7:0] fast_format_value;
      logic [7:0] normal_format_value;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb565_to_rgb666_fill_stream.sv =====
// RGB565 to RGB666 fill stream, top level: CSRs, front end, job queue, back end.
// Depends on rgbfs_pkg, rgbfs_front, rgbfs_queue and rgbfs_back.
//
// Usage
//  - req_*: one word per pixel (kind 0) or fill request (kind 1), taken when
//    req_valid is high and req_stall low. req_stall is high only while the
//    four-entry job queue is full.
//  - rsp_*: display byte-burst descriptors, one word per handshake, held in an
//    output register; rsp_last flags the final descriptor of a request.
//  - csr_*: write-only registers, written while the block is idle; the user
//    must keep to this, as the block itself does not enforce it.
//  - A word taken goes through the job queue and then the output register to rsp_*.
//  - Throughput: one descriptor per cycle from the back end while rsp_stall
//    is low, so pixels and plain-colour fills go at one word per cycle; a
//    pure-colour fill gives one, six or seven descriptors (back-end sequencer).
//  - A fill of zero pixels is taken and gives nothing.
//  - rsp_stall freezes the output register; the queue keeps taking words
//    until it fills.
//  - Reset (synchronous) empties the queue, drops the output word and loads
//    the CSR defaults.
`default_nettype none

module rgb565_to_rgb666_fill_stream #(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_kind,
   input  wire logic [15:0]            req_color,
   input  wire logic [COUNT_BITS-1:0]  req_pixel_count,
   input  wire logic                   req_end_of_block,
   // response channel
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_is_command,
   output      logic [1:0]             rsp_byte_count,
   output      logic [7:0]             rsp_first_byte,
   output      logic [7:0]             rsp_second_byte,
   output      logic [7:0]             rsp_third_byte,
   output      logic [COUNT_BITS-1:0]  rsp_repeat_res,
   output      logic                   rsp_block_end,
   output      logic                   rsp_last,
   // register write port
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic [7:0]             csr_write_data
);
   import rgbfs_pkg::*;

   // register map
   localparam logic [1:0] CSR_FORMAT_COMMAND      = 2'd0;
   localparam logic [1:0] CSR_CONTINUE_COMMAND    = 2'd1;
   localparam logic [1:0] CSR_FAST_FORMAT_VALUE   = 2'd2;
   localparam logic [1:0] CSR_NORMAL_FORMAT_VALUE = 2'd3;

   localparam cfg_type CFG_RESET = '{
      format_command:      8'd58,
      continue_command:    8'd60,
      fast_format_value:   8'd97,
      normal_format_value: 8'd102
   };

   cfg_type               cfg_ff, cfg_in;
   logic                  push;
   job_type               push_job;
   logic                  pop;
   logic                  queue_full;
   logic                  queue_empty;
   job_type               head_job;
   logic [COUNT_BITS-1:0] head_count;

   // CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FORMAT_COMMAND:      cfg_in.format_command      = csr_write_data;
            CSR_CONTINUE_COMMAND:    cfg_in.continue_command    = csr_write_data;
            CSR_FAST_FORMAT_VALUE:   cfg_in.fast_format_value   = csr_write_data;
            CSR_NORMAL_FORMAT_VALUE: cfg_in.normal_format_value = csr_write_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall depends on queue occupancy only, never on req_valid
   assign req_stall = queue_full;

   rgbfs_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_kind         (req_kind),
      .req_color        (req_color),
      .req_pixel_count  (req_pixel_count),
      .req_end_of_block (req_end_of_block),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   rgbfs_queue #(
      .COUNT_BITS(COUNT_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_count (req_pixel_count),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head_job   (head_job),
      .head_count (head_count)
   );

   rgbfs_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (!queue_empty),
      .head_job        (head_job),
      .head_count      (head_count),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_command  (rsp_is_command),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_first_byte  (rsp_first_byte),
      .rsp_second_byte (rsp_second_byte),
      .rsp_third_byte  (rsp_third_byte),
      .rsp_repeat_res  (rsp_repeat_res),
      .rsp_block_end   (rsp_block_end),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/rgbfs_front.sv =====
// Front end: classifies an incoming word into a job and converts its colour.
// Depends on rgbfs_pkg.
`default_nettype none

module rgbfs_front #(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                   req_valid,
   input  wire logic                   req_kind,
   input  wire logic [15:0]            req_color,
   input  wire logic [COUNT_BITS-1:0]  req_pixel_count,
   input  wire logic                   req_end_of_block,
   input  wire logic                   queue_full,
   output      logic                   push,
   output      rgbfs_pkg::job_type     push_job
);
   import rgbfs_pkg::*;

   // 5-to-6-bit rounding, already shifted into the top of the byte
   function automatic logic [7:0] round5to6(input logic [4:0] v);
      logic [7:0] r;
      r = 8'h00;
      unique case (v)
         5'd0:  r = 8'h00;  5'd1:  r = 8'h08;  5'd2:  r = 8'h10;  5'd3:  r = 8'h18;
         5'd4:  r = 8'h20;  5'd5:  r = 8'h28;  5'd6:  r = 8'h30;  5'd7:  r = 8'h38;
         5'd8:  r = 8'h40;  5'd9:  r = 8'h48;  5'd10: r = 8'h50;  5'd11: r = 8'h58;
         5'd12: r = 8'h60;  5'd13: r = 8'h68;  5'd14: r = 8'h70;  5'd15: r = 8'h78;
         5'd16: r = 8'h80;  5'd17: r = 8'h88;  5'd18: r = 8'h94;  5'd19: r = 8'h9C;
         5'd20: r = 8'hA4;  5'd21: r = 8'hAC;  5'd22: r = 8'hB4;  5'd23: r = 8'hBC;
         5'd24: r = 8'hC4;  5'd25: r = 8'hCC;  5'd26: r = 8'hD4;  5'd27: r = 8'hDC;
         5'd28: r = 8'hE4;  5'd29: r = 8'hEC;  5'd30: r = 8'hF4;  5'd31: r = 8'hFC;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   logic       is_pure;
   logic [5:0] pure_code;
   logic       zero_fill;

   always_comb begin
      is_pure   = 1'b1;
      pure_code = 6'h00;
      unique case (req_color)
         16'h0000: pure_code = 6'h00;
         16'h001F: pure_code = 6'h09;
         16'h07E0: pure_code = 6'h12;
         16'h07FF: pure_code = 6'h1B;
         16'hF800: pure_code = 6'h24;
         16'hF81F: pure_code = 6'h2D;
         16'hFFE0: pure_code = 6'h36;
         16'hFFFF: pure_code = 6'h3F;
         default: begin
            is_pure   = 1'b0;
            pure_code = 6'h00;
         end
      endcase
   end

   assign zero_fill = req_kind && (req_pixel_count == '0);

   always_comb begin
      push_job.code        = pure_code;
      push_job.first_byte  = round5to6(req_color[15:11]);
      push_job.second_byte = {req_color[10:5], 2'b00};
      push_job.third_byte  = round5to6(req_color[4:0]);
      if (!req_kind) begin
         push_job.kind      = JOB_PIXEL;
         push_job.block_end = req_end_of_block;
      end else begin
         push_job.kind      = is_pure ? JOB_PURE : JOB_FILL;
         push_job.block_end = 1'b0;
      end
   end

   // a fill of zero pixels is taken and dropped
   assign push = req_valid && !queue_full && !zero_fill;

endmodule

`default_nettype wire

// ===== hw/rtl/rgbfs_queue.sv =====
// Short job queue between front and back end, count carried alongside.
// Depends on rgbfs_pkg.
`default_nettype none

module rgbfs_queue #(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire rgbfs_pkg::job_type     push_job,
   input  wire logic [COUNT_BITS-1:0]  push_count,
   input  wire logic                   pop,
   output      logic                   full,
   output      logic                   empty,
   output      rgbfs_pkg::job_type     head_job,
   output      logic [COUNT_BITS-1:0]  head_count
);
   import rgbfs_pkg::*;

   localparam logic [QPTR_BITS:0] DEPTH_FILL = (QPTR_BITS + 1)'(QUEUE_DEPTH);

   job_type               jobs_ff   [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] counts_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]    fill_ff, fill_in;

   assign full       = (fill_ff == DEPTH_FILL);
   assign empty      = (fill_ff == '0);
   assign head_job   = jobs_ff[rd_ptr_ff];
   assign head_count = counts_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = QPTR_BITS'((QPTR_BITS + 1)'(wr_ptr_ff) + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QPTR_BITS'((QPTR_BITS + 1)'(rd_ptr_ff) + 1'b1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         jobs_ff[wr_ptr_ff]   <= push_job;
         counts_ff[wr_ptr_ff] <= push_count;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rgbfs_back.sv =====
// Back end: walks each job through its descriptors into the output register.
// Depends on rgbfs_pkg.
`default_nettype none

module rgbfs_back #(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rgbfs_pkg::cfg_type     cfg,
   input  wire logic                   head_valid,
   input  wire rgbfs_pkg::job_type     head_job,
   input  wire logic [COUNT_BITS-1:0]  head_count,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_is_command,
   output      logic [1:0]             rsp_byte_count,
   output      logic [7:0]             rsp_first_byte,
   output      logic [7:0]             rsp_second_byte,
   output      logic [7:0]             rsp_third_byte,
   output      logic [COUNT_BITS-1:0]  rsp_repeat_res,
   output      logic                   rsp_block_end,
   output      logic                   rsp_last
);
   import rgbfs_pkg::*;

   // descriptor steps of a pure-colour fill
   localparam logic [2:0] STEP_ODD         = 3'd0;
   localparam logic [2:0] STEP_FMT_CMD     = 3'd1;
   localparam logic [2:0] STEP_FAST_VAL    = 3'd2;
   localparam logic [2:0] STEP_CONT_CMD    = 3'd3;
   localparam logic [2:0] STEP_PAIRS       = 3'd4;
   localparam logic [2:0] STEP_RESTORE_CMD = 3'd5;
   localparam logic [2:0] STEP_NORMAL_VAL  = 3'd6;

   localparam logic [1:0] BYTES_ONE   = 2'd1;
   localparam logic [1:0] BYTES_THREE = 2'd3;
   localparam logic [7:0] FULL_LEVEL  = 8'hFC;

   localparam logic [COUNT_BITS-1:0] REPEAT_ONE = COUNT_BITS'(1);

   logic [2:0]            step_ff, step_in;
   logic [2:0]            step_cur;
   logic [COUNT_BITS-1:0] pairs;
   logic                  advance;
   logic                  out_last;

   logic                  valid_ff, valid_in;
   logic                  is_command_ff, is_command_in;
   logic [1:0]            byte_count_ff, byte_count_in;
   logic [7:0]            first_ff, first_in;
   logic [7:0]            second_ff, second_in;
   logic [7:0]            third_ff, third_in;
   logic [COUNT_BITS-1:0] repeat_ff, repeat_in;
   logic                  block_end_ff, block_end_in;
   logic                  last_ff, last_in;

   assign pairs    = head_count >> 1;
   // even count: no odd pixel group
   assign step_cur = (step_ff == STEP_ODD && !head_count[0]) ? STEP_FMT_CMD : step_ff;
   assign advance  = head_valid && (!valid_ff || !rsp_stall);
   assign pop      = advance && out_last;

   always_comb begin
      is_command_in = 1'b0;
      byte_count_in = BYTES_THREE;
      first_in      = head_job.first_byte;
      second_in     = head_job.second_byte;
      third_in      = head_job.third_byte;
      repeat_in     = REPEAT_ONE;
      block_end_in  = 1'b0;
      out_last      = 1'b1;
      unique case (head_job.kind)
         JOB_PIXEL: begin
            block_end_in = head_job.block_end;
         end
         JOB_FILL: begin
            repeat_in = head_count;
         end
         JOB_PURE: begin
            byte_count_in = BYTES_ONE;
            second_in     = 8'h00;
            third_in      = 8'h00;
            out_last      = 1'b0;
            unique case (step_cur)
               STEP_ODD: begin
                  byte_count_in = BYTES_THREE;
                  first_in      = head_job.code[2] ? FULL_LEVEL : 8'h00;
                  second_in     = head_job.code[1] ? FULL_LEVEL : 8'h00;
                  third_in      = head_job.code[0] ? FULL_LEVEL : 8'h00;
                  out_last      = (pairs == '0);
               end
               STEP_FMT_CMD: begin
                  is_command_in = 1'b1;
                  first_in      = cfg.format_command;
               end
               STEP_FAST_VAL: begin
                  first_in = cfg.fast_format_value;
               end
               STEP_CONT_CMD: begin
                  is_command_in = 1'b1;
                  first_in      = cfg.continue_command;
               end
               STEP_PAIRS: begin
                  first_in  = {2'b00, head_job.code};
                  repeat_in = pairs;
               end
               STEP_RESTORE_CMD: begin
                  is_command_in = 1'b1;
                  first_in      = cfg.format_command;
               end
               STEP_NORMAL_VAL: begin
                  first_in = cfg.normal_format_value;
                  out_last = 1'b1;
               end
               default: begin
                  first_in = cfg.normal_format_value;
                  out_last = 1'b1;
               end
            endcase
         end
         default: begin
            block_end_in = 1'b0;
         end
      endcase
      last_in = out_last;
   end

   always_comb begin
      step_in = step_ff;
      if (advance) begin
         step_in = out_last ? STEP_ODD : step_cur + 3'd1;
      end
      if (advance) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_ODD;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         is_command_ff <= is_command_in;
         byte_count_ff <= byte_count_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         third_ff      <= third_in;
         repeat_ff     <= repeat_in;
         block_end_ff  <= block_end_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_is_command  = is_command_ff;
   assign rsp_byte_count  = byte_count_ff;
   assign rsp_first_byte  = first_ff;
   assign rsp_second_byte = second_ff;
   assign rsp_third_byte  = third_ff;
   assign rsp_repeat_res  = repeat_ff;
   assign rsp_block_end   = block_end_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire
